@@ src/mdnt_pkg.sv @@
package mdnt_pkg;

    localparam int LEVEL_W = 8;
    localparam int BINS = 256;
    localparam int BIN_AW = 8;
    localparam int GAIN_W = 11;
    localparam int THR_W = 10;
    localparam int STATUS_W = 2;

    localparam logic [1:0] REG_PREV_GAIN = 2'd0;
    localparam logic [1:0] REG_NEW_GAIN = 2'd1;
    localparam logic [1:0] REG_MAX_THR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW = 2'd2;

    localparam int MIN_PIXELS = 1000;
    localparam int BRIGHT_FLOOR = 40;
    localparam int DIFF_SCALE = 120;
    localparam int THR_MIN = 30;
    localparam int THR_OFFSET = 12;

    typedef struct packed {
        logic [7:0] red_prev;
        logic [7:0] green_prev;
        logic [7:0] blue_prev;
        logic [7:0] red_new;
        logic [7:0] green_new;
        logic [7:0] blue_new;
        logic       include_pixel;
        logic       last_pixel;
    } pixel_t;

    // result from the level unit to the frame control
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               include_pixel;
        logic               last_pixel;
    } level_t;

endpackage

@@ src/mdnt_ram.sv @@
module mdnt_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/mdnt_level.sv @@
// multi-cycle difference level unit: scale, sum, then restoring divide
module mdnt_level (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  mdnt_pkg::pixel_t          pix,
    input  logic [mdnt_pkg::GAIN_W-1:0] prev_gain,
    input  logic [mdnt_pkg::GAIN_W-1:0] new_gain,
    output logic                      done,
    output mdnt_pkg::level_t          res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM = 2'd1;
    localparam logic [1:0] S_DIV = 2'd2;
    localparam int QW = 20;

    logic [1:0] state_reg;
    logic [18:0] pr_reg [3], nw_reg [3];
    logic [18:0] mp, mn;
    logic [18:0] ar, ag, ab;
    logic [20:0] sum;
    logic [18:0] bright_c;
    logic [QW-1:0] num_reg;
    logic [10:0] den_reg;
    logic [11:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [4:0] cnt_reg;
    logic inc_reg, last_reg;
    logic [11:0] trial;
    logic [QW-1:0] qsat;

    function automatic logic [18:0] mx3(input logic [18:0] a, b, c);
        logic [18:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

    function automatic logic [18:0] ad(input logic [18:0] a, b);
        return a > b ? a - b : b - a;
    endfunction

    always_comb begin
        mp = mx3(pr_reg[0], pr_reg[1], pr_reg[2]);
        mn = mx3(nw_reg[0], nw_reg[1], nw_reg[2]);
        bright_c = ((mp > mn) ? mp : mn) >> 8;
        if (bright_c < 19'(mdnt_pkg::BRIGHT_FLOOR)) bright_c = 19'(mdnt_pkg::BRIGHT_FLOOR);
        ar = ad(pr_reg[0], nw_reg[0]);
        ag = ad(pr_reg[1], nw_reg[1]);
        ab = ad(pr_reg[2], nw_reg[2]);
        sum = 21'(ar) + {1'b0, ag, 1'b0} + 21'(ab);
        trial = {rem_reg[10:0], num_reg[QW-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE: if (start) state_reg <= S_SUM;
                S_SUM: state_reg <= S_DIV;
                S_DIV: if (cnt_reg == 5'(QW - 1)) begin
                    state_reg <= S_IDLE;
                    done <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // bright is below 2^11 since max gain product >> 8 fits; numerator (sum>>8)*120
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: if (start) begin
                pr_reg[0] <= pix.red_prev * prev_gain;
                pr_reg[1] <= pix.green_prev * prev_gain;
                pr_reg[2] <= pix.blue_prev * prev_gain;
                nw_reg[0] <= pix.red_new * new_gain;
                nw_reg[1] <= pix.green_new * new_gain;
                nw_reg[2] <= pix.blue_new * new_gain;
                inc_reg <= pix.include_pixel;
                last_reg <= pix.last_pixel;
            end
            S_SUM: begin
                num_reg <= QW'((sum >> 8) * 7'(mdnt_pkg::DIFF_SCALE));
                den_reg <= bright_c[10:0];
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV: begin
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= trial - {1'b0, den_reg};
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign qsat = quo_reg;
    always_comb begin
        res.include_pixel = inc_reg;
        res.last_pixel = last_reg;
        if (!inc_reg) res.level = '0;
        else if (qsat > QW'(255)) res.level = 8'hff;
        else res.level = qsat[7:0];
    end

endmodule

@@ src/motion_diff_noise_threshold.sv @@
// channel | ports        | payload
// input   | s_axis_t*    | tdata: rgb prev, rgb new (48b); tuser: include; tlast: last pixel
// result  | m_axis_t*    | tdata: diff_level, threshold, status (20b, padded to 24)
// config  | cfg_*        | index 0 prev_gain, 1 new_gain, 2 max_threshold
// between one input transfer and the next a pixel is scaled and summed, divided in 20 steps,
// handed off, counted by a histogram read-modify-write and loaded to the output.
// the result is loaded in F_OUT once the output is free.
// a frame's last pixel adds a histogram scan before its result and a histogram clear after.
// after reset a clearing pass runs over all 256 histogram bins before input is taken.
// a held result does not stop the next pixel being taken; that pixel waits before the
// output load until the held result is transferred.
module motion_diff_noise_threshold #(
    parameter int MAX_FRAME_PIXELS = 4194304
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // red_prev, green_prev, blue_prev, red_new, green_new, blue_new
    input  logic        s_axis_tuser,   // include_pixel
    input  logic        s_axis_tlast,   // last_pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // diff_level, threshold, status, zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int CW = $clog2(MAX_FRAME_PIXELS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_FRAME_PIXELS);
    // x / 3 as (x * RECIP3) >> 27, exact for x below 2^27
    localparam logic [25:0] RECIP3 = 26'd44739243;

    localparam logic [2:0] F_CLR = 3'd0;
    localparam logic [2:0] F_IDLE = 3'd1;
    localparam logic [2:0] F_LVL = 3'd2;
    localparam logic [2:0] F_RD = 3'd3;
    localparam logic [2:0] F_WR = 3'd4;
    localparam logic [2:0] F_SCAN = 3'd5;
    localparam logic [2:0] F_OUT = 3'd6;

    logic [2:0] st_reg;
    logic [10:0] pg_reg, ng_reg;
    logic [9:0] mt_reg;
    mdnt_pkg::pixel_t pix;
    mdnt_pkg::level_t lres, lres_reg;
    logic lstart, ldone;
    logic [CW-1:0] cnt_reg, target_reg;
    logic [CW:0] cum_reg;
    logic [8:0] addr_reg;
    logic ram_we;
    logic [7:0] ram_wa, ram_ra;
    logic [CW-1:0] ram_wd, ram_rd;
    logic found_reg;
    logic [8:0] a_reg;
    logic [10:0] thr_c;
    logic ov_reg;
    logic out_load;
    logic [7:0] olvl_reg;
    logic [9:0] othr_reg;
    logic [1:0] ost_reg;
    logic [CW+1:0] twice;
    logic [CW+27:0] tprod;
    logic [CW-1:0] tgt_c;

    assign pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                  s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40],
                  s_axis_tuser, s_axis_tlast};

    assign s_axis_tready = (st_reg == F_IDLE);
    assign lstart = s_axis_tvalid && s_axis_tready;
    assign out_load = (st_reg == F_OUT) && (!ov_reg || m_axis_tready);

    mdnt_level u_level (
        .aclk, .aresetn, .start(lstart), .pix,
        .prev_gain(pg_reg), .new_gain(ng_reg), .done(ldone), .res(lres)
    );

    mdnt_ram #(.WIDTH(CW), .DEPTH(mdnt_pkg::BINS)) u_hist (
        .aclk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(ram_ra), .rdata(ram_rd)
    );

    always_comb begin
        ram_we = 1'b0;
        ram_wa = addr_reg[7:0];
        ram_wd = '0;
        ram_ra = addr_reg[7:0];
        if (st_reg == F_CLR) ram_we = 1'b1;
        if (st_reg == F_RD) ram_ra = lres_reg.level;
        if (st_reg == F_WR && lres_reg.include_pixel) begin
            ram_we = 1'b1;
            ram_wa = lres_reg.level;
            ram_wd = (ram_rd < CMAX) ? ram_rd + 1'b1 : CMAX;
        end
        thr_c = 11'(a_reg) * 11'd3 + 11'(mdnt_pkg::THR_OFFSET);
        if (thr_c < 11'(mdnt_pkg::THR_MIN)) thr_c = 11'(mdnt_pkg::THR_MIN);
        if (thr_c > 11'(mt_reg)) thr_c = 11'(mt_reg);
        twice = {2'b0, cnt_reg} << 1;
        tprod = (CW+28)'(twice) * (CW+28)'(RECIP3);
        tgt_c = tprod[CW+26:27];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pg_reg <= 11'd256;
            ng_reg <= 11'd256;
            mt_reg <= 10'd180;
        end else if (cfg_we) begin
            case (cfg_index)
                mdnt_pkg::REG_PREV_GAIN: pg_reg <= cfg_data;
                mdnt_pkg::REG_NEW_GAIN: ng_reg <= cfg_data;
                mdnt_pkg::REG_MAX_THR: mt_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // scan reads bin addr while the previous read is summed; summing stops at the first hit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= F_CLR;
            addr_reg <= '0;
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (out_load) ov_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) ov_reg <= 1'b0;
            case (st_reg)
                F_CLR: begin
                    if (addr_reg == 9'd255) begin
                        st_reg <= F_IDLE;
                        addr_reg <= '0;
                    end else begin
                        addr_reg <= addr_reg + 9'd1;
                    end
                end
                F_IDLE: if (lstart) st_reg <= F_LVL;
                F_LVL: if (ldone) begin
                    lres_reg <= lres;
                    st_reg <= F_RD;
                end
                F_RD: st_reg <= F_WR;
                F_WR: begin
                    cnt_reg <= (cnt_reg < CMAX) ? cnt_reg + 1'b1 : CMAX;
                    if (lres_reg.last_pixel) begin
                        st_reg <= F_SCAN;
                        addr_reg <= '0;
                        cum_reg <= '0;
                        found_reg <= 1'b0;
                        a_reg <= 9'd256;
                    end else begin
                        st_reg <= F_OUT;
                    end
                end
                F_SCAN: begin
                    target_reg <= tgt_c;
                    addr_reg <= addr_reg + 9'd1;
                    if (addr_reg != 9'd0 && !found_reg) begin
                        if (cum_reg >= {1'b0, target_reg}) begin
                            found_reg <= 1'b1;
                            a_reg <= addr_reg - 9'd1;
                        end else begin
                            cum_reg <= cum_reg + {1'b0, ram_rd};
                        end
                    end
                    if (addr_reg == 9'd256) st_reg <= F_OUT;
                end
                F_OUT: if (out_load) begin
                    olvl_reg <= lres_reg.level;
                    if (lres_reg.last_pixel && cnt_reg >= CW'(mdnt_pkg::MIN_PIXELS)) begin
                        ost_reg <= mdnt_pkg::ST_VALID;
                        othr_reg <= thr_c[9:0];
                    end else if (lres_reg.last_pixel) begin
                        ost_reg <= mdnt_pkg::ST_FEW;
                        othr_reg <= '0;
                    end else begin
                        ost_reg <= mdnt_pkg::ST_NONE;
                        othr_reg <= '0;
                    end
                    if (lres_reg.last_pixel) begin
                        cnt_reg <= '0;
                        addr_reg <= '0;
                        st_reg <= F_CLR;
                    end else begin
                        st_reg <= F_IDLE;
                    end
                end
                default: st_reg <= F_CLR;
            endcase
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {4'd0, ost_reg, othr_reg, olvl_reg};

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (ost_reg != 2'd3)) else $error("bad status");
    a_thr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && ost_reg != mdnt_pkg::ST_VALID |-> othr_reg == '0)
        else $error("threshold without status");
    a_no_take_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == F_CLR |-> !s_axis_tready) else $error("input during clear");

endmodule
